// ===== rtl/awbr_pkg.sv =====
// Shared types and constants for the area-weighted box resampler.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package awbr_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_SPAN   = 8;
    localparam int FRAC_BITS  = 8;

    // Field widths fixed by the interface.
    localparam int EDGE_W = 19;
    localparam int SW_W   = 10;
    localparam int SH_W   = 9;
    localparam int PX_W   = 9;
    localparam int PY_W   = 8;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int STAT_W = 2;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // Pixel index after truncation, signed.
    localparam int IDX_W  = EDGE_W + 1 - FRAC_BITS;
    localparam int CNT_W  = $clog2(MAX_SPAN);
    // Axis weight, product weight, weighted channel, and the two sums.
    localparam int AW_W   = FRAC_BITS + 3;
    localparam int WT_W   = 2 * AW_W;
    localparam int PR_W   = WT_W + CH_W + 1;
    localparam int TOT_W  = WT_W + 2 * CNT_W;
    localparam int SUM_W  = PR_W + 2 * CNT_W;
    // Quotient bits of a byte, plus one saturation step.
    localparam int K_W    = $clog2(CH_W + 1);

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SPAN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic             wr;
        logic             load;
        logic             setup;
        logic             step;
        logic [CNT_W-1:0] ix;
        logic [CNT_W-1:0] iy;
        logic             div_init;
        logic             div_step;
        logic [K_W-1:0]   div_k;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic             span_bad;
        logic             empty;
        logic             pipe_busy;
        logic             out_free;
        logic [CNT_W-1:0] nx_m1;
        logic [CNT_W-1:0] ny_m1;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/awbr_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Stands alone; holds the source image of the resampler.
`timescale 1ns / 1ps
`default_nettype none

module awbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/awbr_ctrl.sv =====
// Sequencer of the resampler: handshake, span walk and divider steps.
// Depends on awbr_pkg; drives the datapath by command words only.
`timescale 1ns / 1ps
`default_nettype none

module awbr_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_command,
    output logic                 o_in_ready,
    input  awbr_pkg::t_stat      i_stat,
    output awbr_pkg::t_cmd       o_cmd
);

    import awbr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DINIT  = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_ix, n_ix, r_iy, n_iy;
    logic [K_W-1:0]   r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ix    <= '0;
            r_iy    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_ix    <= n_ix;
            r_iy    <= n_iy;
            r_k     <= n_k;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ix    = r_ix;
        n_iy    = r_iy;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.ix    = r_ix;
        o_cmd.iy    = r_iy;
        o_cmd.div_k = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_QUERY) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SETUP;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                n_ix = '0;
                n_iy = '0;
                if (i_stat.span_bad || i_stat.empty) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (r_ix == i_stat.nx_m1) begin
                    n_ix = '0;
                    if (r_iy == i_stat.ny_m1) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_iy = r_iy + 1'b1;
                    end
                end else begin
                    n_ix = r_ix + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_k            = K_W'(CH_W);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_k == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/awbr_dp.sv =====
// Datapath of the resampler: registers, image store, weight pipeline,
// accumulators, restoring divider and result register. Depends on awbr_pkg
// and awbr_ram.
`timescale 1ns / 1ps
`default_nettype none

module awbr_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  awbr_pkg::t_cmd                   i_cmd,
    output awbr_pkg::t_stat                  o_stat,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_index,
    input  wire  [awbr_pkg::SW_W-1:0]        i_cfg_data,
    input  wire  [awbr_pkg::PX_W-1:0]        i_pixel_x,
    input  wire  [awbr_pkg::PY_W-1:0]        i_pixel_y,
    input  wire  [awbr_pkg::CH_W-1:0]        i_red_in,
    input  wire  [awbr_pkg::CH_W-1:0]        i_green_in,
    input  wire  [awbr_pkg::CH_W-1:0]        i_blue_in,
    input  wire  signed [awbr_pkg::EDGE_W-1:0] i_left_x,
    input  wire  signed [awbr_pkg::EDGE_W-1:0] i_top_y,
    input  wire  signed [awbr_pkg::EDGE_W-1:0] i_right_x,
    input  wire  signed [awbr_pkg::EDGE_W-1:0] i_bottom_y,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [awbr_pkg::CH_W-1:0]        o_red_out,
    output logic [awbr_pkg::CH_W-1:0]        o_green_out,
    output logic [awbr_pkg::CH_W-1:0]        o_blue_out,
    output logic [awbr_pkg::STAT_W-1:0]      o_status
);

    import awbr_pkg::*;

    localparam int NCH  = 3;
    localparam int TW   = EDGE_W + 2;
    localparam int IX_W = IDX_W + 1;
    localparam logic signed [AW_W-1:0] W_ONE = AW_W'(1 << FRAC_BITS);

    function automatic logic signed [IDX_W-1:0] trunc_idx(
        input logic signed [EDGE_W-1:0] v
    );
        logic signed [EDGE_W:0] ve;
        logic [EDGE_W:0]        mag;
        logic [IDX_W-1:0]       q;
        ve  = (EDGE_W + 1)'(v);
        mag = v[EDGE_W-1] ? unsigned'(-ve) : unsigned'(ve);
        q   = mag[EDGE_W:FRAC_BITS];
        return v[EDGE_W-1] ? -$signed(q) : $signed(q);
    endfunction

    // Weight of the first pixel on an axis, or of the only one.
    function automatic logic signed [AW_W-1:0] w_first(
        input logic signed [EDGE_W-1:0] lo,
        input logic signed [EDGE_W-1:0] hi,
        input logic signed [IDX_W-1:0]  lo_i,
        input logic                     single
    );
        logic signed [TW-1:0] t;
        if (single) begin
            t = TW'(hi) - TW'(lo);
        end else begin
            t = (TW'(lo_i) <<< FRAC_BITS) + TW'(W_ONE) - TW'(lo);
        end
        return AW_W'(t);
    endfunction

    function automatic logic signed [AW_W-1:0] w_last(
        input logic signed [EDGE_W-1:0] hi,
        input logic signed [IDX_W-1:0]  hi_i
    );
        logic signed [TW-1:0] t;
        t = TW'(hi) - (TW'(hi_i) <<< FRAC_BITS);
        return AW_W'(t);
    endfunction

    // Configuration.
    logic [SW_W-1:0] r_src_w;
    logic [SH_W-1:0] r_src_h;
    logic [SH_W-1:0] cfg_h;

    assign cfg_h = i_cfg_data[SH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SW_W'(MAX_WIDTH);
            r_src_h <= SH_W'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_WIDTH) begin
                if (i_cfg_data == '0) begin
                    r_src_w <= SW_W'(1);
                end else if (i_cfg_data > SW_W'(MAX_WIDTH)) begin
                    r_src_w <= SW_W'(MAX_WIDTH);
                end else begin
                    r_src_w <= i_cfg_data;
                end
            end else begin
                if (cfg_h == '0) begin
                    r_src_h <= SH_W'(1);
                end else if (cfg_h > SH_W'(MAX_HEIGHT)) begin
                    r_src_h <= SH_W'(MAX_HEIGHT);
                end else begin
                    r_src_h <= cfg_h;
                end
            end
        end
    end

    // Query edges, latched when the word is taken.
    logic signed [EDGE_W-1:0] r_lx, r_ty, r_rx, r_by;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lx <= i_left_x;
            r_ty <= i_top_y;
            r_rx <= i_right_x;
            r_by <= i_bottom_y;
        end
    end

    // Span setup.
    logic signed [IDX_W-1:0] lxi, tyi, rxi, byi;
    logic signed [IX_W-1:0]  nx, ny;
    logic signed [IDX_W-1:0] r_lxi, r_tyi;
    logic [CNT_W-1:0]        r_nx_m1, r_ny_m1;
    logic                    r_span_bad, r_empty;
    logic signed [AW_W-1:0]  r_xw_first, r_xw_last, r_yw_first, r_yw_last;

    assign lxi = trunc_idx(r_lx);
    assign tyi = trunc_idx(r_ty);
    assign rxi = trunc_idx(r_rx);
    assign byi = trunc_idx(r_by);
    assign nx  = IX_W'(rxi) - IX_W'(lxi) + IX_W'(1);
    assign ny  = IX_W'(byi) - IX_W'(tyi) + IX_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_lxi      <= lxi;
            r_tyi      <= tyi;
            r_nx_m1    <= CNT_W'(nx - IX_W'(1));
            r_ny_m1    <= CNT_W'(ny - IX_W'(1));
            r_span_bad <= (nx > IX_W'(MAX_SPAN)) || (ny > IX_W'(MAX_SPAN));
            r_empty    <= (nx < IX_W'(1)) || (ny < IX_W'(1));
            r_xw_first <= w_first(r_lx, r_rx, lxi, nx == IX_W'(1));
            r_xw_last  <= w_last(r_rx, rxi);
            r_yw_first <= w_first(r_ty, r_by, tyi, ny == IX_W'(1));
            r_yw_last  <= w_last(r_by, byi);
        end
    end

    // Stage 0: wrap the column, form the address and the product weight.
    logic signed [IX_W-1:0] w_s, h_s, s_col, s_colw, s_row;
    logic                   pix_ok;
    logic signed [AW_W-1:0] xw, yw;
    logic [ADDR_W-1:0]      raddr, waddr;
    logic                   wr_ok;
    logic [PIX_W-1:0]       rdata;

    assign w_s   = $signed(IX_W'(r_src_w));
    assign h_s   = $signed(IX_W'(r_src_h));
    assign s_col = IX_W'(r_lxi) + $signed(IX_W'(i_cmd.ix));
    assign s_row = IX_W'(r_tyi) + $signed(IX_W'(i_cmd.iy));

    always_comb begin
        if (s_col < 0) begin
            s_colw = s_col + w_s;
        end else if (s_col >= w_s) begin
            s_colw = s_col - w_s;
        end else begin
            s_colw = s_col;
        end
    end

    assign pix_ok = (s_colw >= 0) && (s_colw < w_s) && (s_row >= 0) && (s_row < h_s);
    assign raddr  = ADDR_W'(s_row[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
                  + ADDR_W'(s_colw[COL_W-1:0]);

    always_comb begin
        if (i_cmd.ix == '0) begin
            xw = r_xw_first;
        end else if (i_cmd.ix == r_nx_m1) begin
            xw = r_xw_last;
        end else begin
            xw = W_ONE;
        end
        if (i_cmd.iy == '0) begin
            yw = r_yw_first;
        end else if (i_cmd.iy == r_ny_m1) begin
            yw = r_yw_last;
        end else begin
            yw = W_ONE;
        end
    end

    // Writes outside the store are dropped.
    assign wr_ok = (32'(i_pixel_x) < 32'(MAX_WIDTH)) && (32'(i_pixel_y) < 32'(MAX_HEIGHT));
    assign waddr = ADDR_W'(i_pixel_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(i_pixel_x);

    awbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr && wr_ok),
        .i_waddr (waddr),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .i_re    (i_cmd.step),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    logic                   r_v0, r_ok0, r_v1;
    logic signed [WT_W-1:0] r_wt0, r_wt1;
    logic signed [PR_W-1:0] r_pr [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_cmd.step;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wt0 <= WT_W'(xw) * WT_W'(yw);
        r_ok0 <= pix_ok;
    end

    // Stage 1: weight times channel. Skipped pixels contribute nothing.
    always_ff @(posedge i_clk) begin
        r_wt1 <= r_ok0 ? r_wt0 : '0;
        for (int c = 0; c < NCH; c++) begin
            r_pr[c] <= r_ok0
                ? PR_W'(r_wt0) * $signed(PR_W'(rdata[(NCH-1-c)*CH_W +: CH_W]))
                : '0;
        end
    end

    // Stage 2: accumulate.
    logic signed [TOT_W-1:0] r_total;
    logic signed [SUM_W-1:0] r_sum [NCH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_total <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= '0;
            end
        end else if (r_v1) begin
            r_total <= r_total + TOT_W'(r_wt1);
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(r_pr[c]);
            end
        end
    end

    // Restoring divider on magnitudes, one quotient bit a step. The first
    // step only checks whether the quotient reaches a full byte.
    logic [TOT_W-1:0]  r_den;
    logic [SUM_W-1:0]  r_rem [NCH];
    logic [CH_W-1:0]   r_q   [NCH];
    logic [NCH-1:0]    r_neg, r_sat;
    logic [SUM_W-1:0]  trial;

    assign trial = SUM_W'(r_den) << i_cmd.div_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_den <= r_total[TOT_W-1] ? unsigned'(-r_total) : unsigned'(r_total);
            for (int c = 0; c < NCH; c++) begin
                r_rem[c] <= r_sum[c][SUM_W-1] ? unsigned'(-r_sum[c]) : unsigned'(r_sum[c]);
                r_neg[c] <= r_sum[c][SUM_W-1] ^ r_total[TOT_W-1];
                r_q[c]   <= '0;
                r_sat[c] <= 1'b0;
            end
        end else if (i_cmd.div_step) begin
            for (int c = 0; c < NCH; c++) begin
                if (i_cmd.div_k == K_W'(CH_W)) begin
                    r_sat[c] <= (r_rem[c] >= trial);
                end else if (r_rem[c] >= trial) begin
                    r_rem[c] <= r_rem[c] - trial;
                    r_q[c][i_cmd.div_k[$clog2(CH_W)-1:0]] <= 1'b1;
                end
            end
        end
    end

    // Result register.
    logic [CH_W-1:0] r_out [NCH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_span_bad) begin
                o_status <= STAT_SPAN;
            end else if (r_total == '0) begin
                o_status <= STAT_ZERO;
            end else begin
                o_status <= STAT_OK;
            end
            for (int c = 0; c < NCH; c++) begin
                if (r_span_bad || r_total == '0 || r_neg[c]) begin
                    r_out[c] <= '0;
                end else if (r_sat[c]) begin
                    r_out[c] <= '1;
                end else begin
                    r_out[c] <= r_q[c];
                end
            end
        end
    end

    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];

    assign o_stat.span_bad  = r_span_bad;
    assign o_stat.empty     = r_empty;
    assign o_stat.pipe_busy = r_v0 || r_v1;
    assign o_stat.out_free  = !o_out_valid || i_out_ready;
    assign o_stat.nx_m1     = r_nx_m1;
    assign o_stat.ny_m1     = r_ny_m1;

endmodule

`default_nettype wire

// ===== rtl/area_weighted_box_resampler_top.sv =====
// Top level of the area-weighted box resampler.
// Depends on awbr_pkg, awbr_ctrl, awbr_dp and awbr_ram.
`timescale 1ns / 1ps
`default_nettype none

// A pixel write word is taken and produces no result. A query word covers
// an nx by ny pixel span: the image memory has one read port, so the span is
// walked one source pixel per cycle, followed by a pipeline drain and a
// nine-step restoring divide shared by the three channels. Out-of-limit
// spans and empty spans skip the walk and the divide. A result waits in its
// own register, so a new word is taken while the previous result is still
// pending. The image memory is not cleared after reset; configuration
// writes are taken at any time.

module area_weighted_box_resampler_top (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_command,
    input  wire  [awbr_pkg::PX_W-1:0]         i_pixel_x,
    input  wire  [awbr_pkg::PY_W-1:0]         i_pixel_y,
    input  wire  [awbr_pkg::CH_W-1:0]         i_red_in,
    input  wire  [awbr_pkg::CH_W-1:0]         i_green_in,
    input  wire  [awbr_pkg::CH_W-1:0]         i_blue_in,
    input  wire  signed [awbr_pkg::EDGE_W-1:0] i_left_x,
    input  wire  signed [awbr_pkg::EDGE_W-1:0] i_top_y,
    input  wire  signed [awbr_pkg::EDGE_W-1:0] i_right_x,
    input  wire  signed [awbr_pkg::EDGE_W-1:0] i_bottom_y,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [awbr_pkg::CH_W-1:0]         o_red_out,
    output logic [awbr_pkg::CH_W-1:0]         o_green_out,
    output logic [awbr_pkg::CH_W-1:0]         o_blue_out,
    output logic [awbr_pkg::STAT_W-1:0]       o_status,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire                               i_cfg_index,
    input  wire  [awbr_pkg::SW_W-1:0]         i_cfg_data
);

    import awbr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    awbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    awbr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_left_x    (i_left_x),
        .i_top_y     (i_top_y),
        .i_right_x   (i_right_x),
        .i_bottom_y  (i_bottom_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire
